### src/sedp_pkg.sv
// Shared types and constants for the STX/ETX/DLE frame parser.
package sedp_pkg;

   localparam int CodeWidth  = 8;
   localparam int PosWidth   = 16;
   localparam int IndexWidth = 2;

   // Reset values of the code registers
   localparam logic [CodeWidth-1:0] START_CODE_RESET  = 8'd2;
   localparam logic [CodeWidth-1:0] END_CODE_RESET    = 8'd3;
   localparam logic [CodeWidth-1:0] ESCAPE_CODE_RESET = 8'd16;

   // Header length and position ceiling
   localparam logic [PosWidth-1:0] HEADER_LEN = 16'd3;
   localparam logic [PosWidth-1:0] POS_MAX    = 16'hFFFF;

   // Register indexes on the csr channel
   typedef enum logic [IndexWidth-1:0] {
      REG_START  = 2'd0,
      REG_END    = 2'd1,
      REG_ESCAPE = 2'd2
   } reg_index_type;

   // Result slot codes
   typedef enum logic [2:0] {
      SLOT_START   = 3'd0,
      SLOT_OPER    = 3'd1,
      SLOT_CMD     = 3'd2,
      SLOT_HWIDX   = 3'd3,
      SLOT_PAYLOAD = 3'd4,
      SLOT_END     = 3'd5
   } slot_type;

   // Current framing codes
   typedef struct packed {
      logic [CodeWidth-1:0] start_code;
      logic [CodeWidth-1:0] end_code;
      logic [CodeWidth-1:0] escape_code;
   } codes_type;

   // One result item plus its valid flag
   typedef struct packed {
      logic                 valid;
      slot_type             slot;
      logic [CodeWidth-1:0] value;
      logic [PosWidth-1:0]  payload_pos;
   } result_type;

endpackage

### src/sedp_csr.sv
// Code registers written through the csr channel.
module sedp_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [sedp_pkg::IndexWidth-1:0]  csr_index,
   input  logic [sedp_pkg::CodeWidth-1:0]   csr_data,
   output sedp_pkg::codes_type              codes
);

   sedp_pkg::codes_type codes_ff, codes_in;

   assign csr_ready = 1'b1;
   assign codes     = codes_ff;

   // Decode the register index; unknown indexes are dropped
   always_comb begin
      codes_in = codes_ff;
      if (csr_valid) begin
         unique case (sedp_pkg::reg_index_type'(csr_index))
            sedp_pkg::REG_START:  codes_in.start_code  = csr_data;
            sedp_pkg::REG_END:    codes_in.end_code    = csr_data;
            sedp_pkg::REG_ESCAPE: codes_in.escape_code = csr_data;
            default:              codes_in = codes_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         codes_ff.start_code  <= sedp_pkg::START_CODE_RESET;
         codes_ff.end_code    <= sedp_pkg::END_CODE_RESET;
         codes_ff.escape_code <= sedp_pkg::ESCAPE_CODE_RESET;
      end else begin
         codes_ff <= codes_in;
      end
   end

endmodule

### src/sedp_decode.sv
// Framing state and byte classification, one byte per transfer.
module sedp_decode (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  logic [sedp_pkg::CodeWidth-1:0]  rx_byte,
   input  sedp_pkg::codes_type             codes,
   output sedp_pkg::result_type            result
);

   logic                           in_frame_ff, in_frame_in;
   logic                           escape_ff, escape_in;
   logic [sedp_pkg::PosWidth-1:0]  position_ff, position_in;
   logic                           start_hit, end_hit, escape_hit;

   assign start_hit  = !in_frame_ff && (rx_byte == codes.start_code) && !escape_ff;
   assign end_hit    = in_frame_ff && (rx_byte == codes.end_code) && !escape_ff;
   assign escape_hit = (rx_byte == codes.escape_code) && !escape_ff;

   // Next framing state and the result for this byte
   always_comb begin
      in_frame_in        = in_frame_ff;
      escape_in          = escape_ff;
      position_in        = position_ff;
      result.valid       = 1'b0;
      result.slot        = sedp_pkg::SLOT_START;
      result.value       = '0;
      result.payload_pos = '0;
      priority if (start_hit) begin
         in_frame_in  = 1'b1;
         position_in  = '0;
         result.valid = 1'b1;
      end else if (end_hit) begin
         in_frame_in  = 1'b0;
         escape_in    = 1'b0;
         result.valid = 1'b1;
         result.slot  = sedp_pkg::SLOT_END;
      end else begin
         escape_in = escape_hit;
         if (!escape_hit && in_frame_ff) begin
            result.valid = 1'b1;
            result.value = rx_byte;
            if (position_ff < sedp_pkg::HEADER_LEN) begin
               unique case (position_ff[1:0])
                  2'd0:    result.slot = sedp_pkg::SLOT_OPER;
                  2'd1:    result.slot = sedp_pkg::SLOT_CMD;
                  default: result.slot = sedp_pkg::SLOT_HWIDX;
               endcase
            end else begin
               result.slot        = sedp_pkg::SLOT_PAYLOAD;
               result.payload_pos = position_ff - sedp_pkg::HEADER_LEN;
            end
            // Saturating byte counter
            if (position_ff != sedp_pkg::POS_MAX) begin
               position_in = position_ff + 16'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff <= 1'b0;
         escape_ff   <= 1'b0;
         position_ff <= '0;
      end else if (accept) begin
         in_frame_ff <= in_frame_in;
         escape_ff   <= escape_in;
         position_ff <= position_in;
      end
   end

   // A start result always leaves a frame open
   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      accept && result.valid && (result.slot == sedp_pkg::SLOT_START) |=> in_frame_ff)
      else $error("start transfer did not open a frame");

   // An end result closes the frame and drops any escape
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      accept && result.valid && (result.slot == sedp_pkg::SLOT_END)
      |=> !in_frame_ff && !escape_ff)
      else $error("end transfer left frame or escape set");

   // An escaped byte never acts as a delimiter
   a_escaped_literal: assert property (@(posedge clock) disable iff (reset)
      escape_ff && result.valid |->
      (result.slot != sedp_pkg::SLOT_START) && (result.slot != sedp_pkg::SLOT_END))
      else $error("escaped byte taken as delimiter");

   // Payload only follows a full header
   a_payload_after_header: assert property (@(posedge clock) disable iff (reset)
      result.valid && (result.slot == sedp_pkg::SLOT_PAYLOAD)
      |-> position_ff >= sedp_pkg::HEADER_LEN)
      else $error("payload before header complete");

endmodule

### src/sedp_out.sv
// Result register between the decoder and the rsp channel.
module sedp_out (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            accept,
   input  sedp_pkg::result_type            result,
   output logic                            take_ok,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_slot,
   output logic [sedp_pkg::CodeWidth-1:0]  rsp_value,
   output logic [sedp_pkg::PosWidth-1:0]   rsp_payload_pos
);

   logic                           valid_ff, valid_in;
   logic [2:0]                     slot_ff;
   logic [sedp_pkg::CodeWidth-1:0] value_ff;
   logic [sedp_pkg::PosWidth-1:0]  pos_ff;
   logic                           load;

   // Register is free when empty or being drained this cycle
   assign take_ok = !valid_ff || rsp_ready;
   assign load    = accept && result.valid;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, no reset needed
   always_ff @(posedge clock) begin
      if (load) begin
         slot_ff  <= result.slot;
         value_ff <= result.value;
         pos_ff   <= result.payload_pos;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_slot        = slot_ff;
   assign rsp_value       = value_ff;
   assign rsp_payload_pos = pos_ff;

   // Every loaded result shows up on the channel next cycle
   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> valid_ff)
      else $error("loaded result not presented");

endmodule

### src/stx_etx_dle_frame_parser.sv
// Top level of the STX/ETX/DLE receive deframer.
//
// Usage:
//   req_*  : one received byte per transfer (req_rx_byte).
//   rsp_*  : zero or one result per byte: slot, unescaped value, payload
//            position. Slot 0 frame start, 1 operation, 2 command,
//            3 hardware index, 4 payload, 5 frame end.
//   csr_*  : register writes, index 0 start code, 1 end code, 2 escape code;
//            other indexes are dropped. csr_ready is always high.
// Result: registered; it appears on rsp in the cycle after its byte's transfer.
// Throughput: one byte per cycle while rsp is not stalled; the framing state
//   updates in the same cycle as the transfer, and the single result register
//   is refilled while it drains.
// Reset: no frame open, no escape pending, position zero, codes back to
//   2 / 3 / 16, result register empty.
// Stall: while rsp_ready is low and a result is held, req_ready is low;
//   req_ready = !rsp_valid || rsp_ready.
module stx_etx_dle_frame_parser (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [sedp_pkg::CodeWidth-1:0]  req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [2:0]                      rsp_slot,
   output logic [sedp_pkg::CodeWidth-1:0]  rsp_value,
   output logic [sedp_pkg::PosWidth-1:0]   rsp_payload_pos,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [sedp_pkg::IndexWidth-1:0] csr_index,
   input  logic [sedp_pkg::CodeWidth-1:0]  csr_data
);

   sedp_pkg::codes_type  codes;
   sedp_pkg::result_type result;
   logic                 take_ok;
   logic                 accept;

   assign req_ready = take_ok;
   assign accept    = req_valid && take_ok;

   sedp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .codes     (codes)
   );

   sedp_decode u_decode (
      .clock   (clock),
      .reset   (reset),
      .accept  (accept),
      .rx_byte (req_rx_byte),
      .codes   (codes),
      .result  (result)
   );

   sedp_out u_out (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .result          (result),
      .take_ok         (take_ok),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_slot        (rsp_slot),
      .rsp_value       (rsp_value),
      .rsp_payload_pos (rsp_payload_pos)
   );

endmodule

### verif/tb_stx_etx_dle_frame_parser.sv
`timescale 1ns / 100ps
// Testbench for the STX/ETX/DLE receive deframer, checked against a local deframing model.
module tb_stx_etx_dle_frame_parser;

   // Index outside the register map, the block must drop it
   localparam logic [sedp_pkg::IndexWidth-1:0] REG_UNUSED = 2'd3;
   localparam int STALL_LIMIT   = 2000;
   localparam int HOLD_CYCLES   = 60;
   localparam int SETTLE_CYCLES = 4;
   localparam int IDLE_PCT      = 8;

   // One deframed field as it appears on the rsp channel
   typedef struct packed {
      sedp_pkg::slot_type             slot;
      logic [sedp_pkg::CodeWidth-1:0] value;
      logic [sedp_pkg::PosWidth-1:0]  pos;
   } frame_field_type;

   logic                            clock       = 1'b0;
   logic                            reset       = 1'b1;
   logic                            req_valid   = 1'b0;
   logic                            req_ready;
   logic [sedp_pkg::CodeWidth-1:0]  req_rx_byte = '0;
   logic                            rsp_valid;
   logic                            rsp_ready   = 1'b0;
   logic [2:0]                      rsp_slot;
   logic [sedp_pkg::CodeWidth-1:0]  rsp_value;
   logic [sedp_pkg::PosWidth-1:0]   rsp_payload_pos;
   logic                            csr_valid   = 1'b0;
   logic                            csr_ready;
   logic [sedp_pkg::IndexWidth-1:0] csr_index   = '0;
   logic [sedp_pkg::CodeWidth-1:0]  csr_data    = '0;

   // Deframer model: code registers and framing state
   logic [sedp_pkg::CodeWidth-1:0] code_start  = sedp_pkg::START_CODE_RESET;
   logic [sedp_pkg::CodeWidth-1:0] code_end    = sedp_pkg::END_CODE_RESET;
   logic [sedp_pkg::CodeWidth-1:0] code_escape = sedp_pkg::ESCAPE_CODE_RESET;
   logic                           frame_open  = 1'b0;
   logic                           esc_pending = 1'b0;
   logic [sedp_pkg::PosWidth-1:0]  data_count  = '0;

   frame_field_type expected_fields[$];
   int error_count  = 0;
   int bytes_sent   = 0;
   int stall_cycles = 0;
   int hold_left    = 0;
   bit hold_request = 1'b0;
   bit no_idle      = 1'b0;

   stx_etx_dle_frame_parser i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_slot        (rsp_slot),
      .rsp_value       (rsp_value),
      .rsp_payload_pos (rsp_payload_pos),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #4 clock = ~clock;

   function automatic void expect_field(sedp_pkg::slot_type s,
                                        logic [sedp_pkg::CodeWidth-1:0] v,
                                        logic [sedp_pkg::PosWidth-1:0] p);
      frame_field_type f;
      f.slot  = s;
      f.value = v;
      f.pos   = p;
      expected_fields.push_back(f);
   endfunction

   // Framing decision for one received byte; open and close win over escape tracking
   function automatic void deframe_byte(logic [sedp_pkg::CodeWidth-1:0] b);
      if (!frame_open && b == code_start && !esc_pending) begin
         frame_open = 1'b1;
         data_count = '0;
         expect_field(sedp_pkg::SLOT_START, '0, '0);
      end else if (frame_open && b == code_end && !esc_pending) begin
         frame_open  = 1'b0;
         esc_pending = 1'b0;
         expect_field(sedp_pkg::SLOT_END, '0, '0);
      end else begin
         esc_pending = (b == code_escape) && !esc_pending;
         if (!esc_pending && frame_open) begin
            case (data_count)
               16'd0:   expect_field(sedp_pkg::SLOT_OPER, b, '0);
               16'd1:   expect_field(sedp_pkg::SLOT_CMD, b, '0);
               16'd2:   expect_field(sedp_pkg::SLOT_HWIDX, b, '0);
               default: expect_field(sedp_pkg::SLOT_PAYLOAD, b,
                                     data_count - sedp_pkg::HEADER_LEN);
            endcase
            // position sticks at the ceiling on long payloads
            if (data_count != sedp_pkg::POS_MAX)
               data_count = data_count + 16'd1;
         end
      end
   endfunction

   function automatic void apply_code_write(logic [sedp_pkg::IndexWidth-1:0] idx,
                                            logic [sedp_pkg::CodeWidth-1:0] d);
      case (idx)
         sedp_pkg::REG_START:  code_start  = d;
         sedp_pkg::REG_END:    code_end    = d;
         sedp_pkg::REG_ESCAPE: code_escape = d;
         default: ;
      endcase
   endfunction

   // Model update on every accepted byte and register transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            deframe_byte(req_rx_byte);
         if (csr_valid && csr_ready)
            apply_code_write(csr_index, csr_data);
      end
   end

   // Result checker: oldest expectation against each rsp transfer
   always @(posedge clock) begin : check_results
      frame_field_type exp_f;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_fields.size() == 0) begin
            error_count++;
            $display("%0t: expected no result, actual slot %0d value 0x%02h pos %0d",
                     $time, rsp_slot, rsp_value, rsp_payload_pos);
         end else begin
            exp_f = expected_fields.pop_front();
            if (rsp_slot !== exp_f.slot) begin
               error_count++;
               $display("%0t: slot expected %0d actual %0d", $time, exp_f.slot, rsp_slot);
            end
            if (rsp_value !== exp_f.value) begin
               error_count++;
               $display("%0t: value expected 0x%02h actual 0x%02h", $time, exp_f.value,
                        rsp_value);
            end
            if (rsp_payload_pos !== exp_f.pos) begin
               error_count++;
               $display("%0t: payload_pos expected %0d actual %0d", $time, exp_f.pos,
                        rsp_payload_pos);
            end
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off on request
   always @(negedge clock) begin
      if (hold_request) begin
         hold_left    = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("[stx_etx_dle_frame_parser] ERROR");
            $finish;
         end
      end
   end

   // One byte transfer; valid stays up afterwards until the next byte or a pause
   task automatic send_byte(input logic [sedp_pkg::CodeWidth-1:0] b);
      if (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Stop sending and wait until every expected field has come out
   task automatic wait_for_results();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_fields.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_code(input logic [sedp_pkg::IndexWidth-1:0] idx,
                             input logic [sedp_pkg::CodeWidth-1:0] d);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_codes(input logic [sedp_pkg::CodeWidth-1:0] s,
                            input logic [sedp_pkg::CodeWidth-1:0] e,
                            input logic [sedp_pkg::CodeWidth-1:0] d);
      wait_for_results();
      if ($urandom_range(1))
         write_code(REG_UNUSED, sedp_pkg::CodeWidth'($urandom_range(255)));
      write_code(sedp_pkg::REG_ESCAPE, d);
      write_code(sedp_pkg::REG_END, e);
      write_code(sedp_pkg::REG_START, s);
   endtask

   // Random byte biased toward the current framing codes
   function automatic logic [sedp_pkg::CodeWidth-1:0] pick_byte();
      case ($urandom_range(7))
         0:       return code_start;
         1:       return code_end;
         2:       return code_escape;
         default: return sedp_pkg::CodeWidth'($urandom_range(255));
      endcase
   endfunction

   function automatic int frame_len();
      return ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12);
   endfunction

   // Data byte inside a frame, escaped when it collides with a code (sometimes not)
   task automatic send_data(input logic [sedp_pkg::CodeWidth-1:0] b, input bit sloppy);
      if ((b == code_start || b == code_end || b == code_escape) &&
          !(sloppy && $urandom_range(4) == 0))
         send_byte(code_escape);
      send_byte(b);
   endtask

   task automatic send_frame(input int data_len, input bit closed, input bit sloppy);
      send_byte(code_start);
      repeat (data_len) send_data(pick_byte(), sloppy);
      if (closed)
         send_byte(code_end);
   endtask

   // Mostly well-formed frames, with noise, open-ended and badly escaped frames mixed in
   task automatic run_traffic(input int n_bytes);
      int target;
      int pick;
      target = bytes_sent + n_bytes;
      while (bytes_sent < target) begin
         pick = $urandom_range(99);
         if (pick < 75) begin
            send_frame(frame_len(), 1'b1, 1'b0);
         end else if (pick < 85) begin
            repeat ($urandom_range(4, 1))
               send_byte($urandom_range(1) ? pick_byte()
                                           : sedp_pkg::CodeWidth'($urandom_range(255)));
         end else if (pick < 93) begin
            send_frame(frame_len(), 1'b0, 1'b1);
         end else begin
            send_byte(code_escape);
            send_frame(frame_len(), 1'b1, 1'b1);
         end
      end
   endtask

   // Reset codes: escapes around frame open, codes as data, short frames
   task automatic test_directed_defaults();
      logic [sedp_pkg::CodeWidth-1:0] seq [0:19] = '{
         sedp_pkg::ESCAPE_CODE_RESET, sedp_pkg::START_CODE_RESET,
         sedp_pkg::ESCAPE_CODE_RESET, sedp_pkg::ESCAPE_CODE_RESET,
         sedp_pkg::START_CODE_RESET,
         8'hA5, 8'h00, 8'hFF,
         sedp_pkg::START_CODE_RESET,
         sedp_pkg::ESCAPE_CODE_RESET, sedp_pkg::END_CODE_RESET,
         sedp_pkg::ESCAPE_CODE_RESET, sedp_pkg::ESCAPE_CODE_RESET,
         8'h7E, sedp_pkg::END_CODE_RESET,
         sedp_pkg::END_CODE_RESET, 8'h55,
         sedp_pkg::START_CODE_RESET, 8'h01, sedp_pkg::END_CODE_RESET
      };
      foreach (seq[i])
         send_byte(seq[i]);
      wait_for_results();
   endtask

   // Extreme and coinciding code values, then back to reset values
   task automatic test_code_settings();
      logic [sedp_pkg::CodeWidth-1:0] codes [0:6][0:2] = '{
         '{8'h00, 8'hFF, 8'h80},
         '{8'hFF, 8'h00, 8'h7F},
         '{8'h5A, 8'h5A, 8'h10},
         '{8'h33, 8'h44, 8'h33},
         '{8'h02, 8'h77, 8'h77},
         '{8'hC3, 8'hC3, 8'hC3},
         '{sedp_pkg::START_CODE_RESET, sedp_pkg::END_CODE_RESET,
           sedp_pkg::ESCAPE_CODE_RESET}
      };
      for (int i = 0; i < 7; i++) begin
         set_codes(codes[i][0], codes[i][1], codes[i][2]);
         if (i == 0)
            write_code(REG_UNUSED, 8'hFF);
         run_traffic(45);
      end
   endtask

   task automatic test_random_frames();
      run_traffic(500);
      repeat (2) begin
         set_codes(sedp_pkg::CodeWidth'($urandom_range(255)),
                   sedp_pkg::CodeWidth'($urandom_range(255)),
                   sedp_pkg::CodeWidth'($urandom_range(255)));
         run_traffic(100);
      end
      set_codes(sedp_pkg::START_CODE_RESET, sedp_pkg::END_CODE_RESET,
                sedp_pkg::ESCAPE_CODE_RESET);
   endtask

   // Receiver holds off while a frame keeps coming, so the input stalls
   task automatic test_backpressure();
      wait_for_results();
      @(posedge clock);
      hold_request = 1'b1;
      send_frame(40, 1'b1, 1'b0);
      wait_for_results();
      send_frame(frame_len(), 1'b1, 1'b0);
      wait_for_results();
   endtask

   task automatic test_no_idle();
      no_idle = 1'b1;
      run_traffic(200);
      wait_for_results();
      no_idle = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_defaults();
      test_code_settings();
      test_random_frames();
      test_backpressure();
      test_no_idle();
      wait_for_results();

      if (error_count == 0 && expected_fields.size() == 0)
         $display("[stx_etx_dle_frame_parser] OK");
      else
         $display("[stx_etx_dle_frame_parser] ERROR");
      $finish;
   end

endmodule

### sim.f
src/sedp_pkg.sv
src/sedp_csr.sv
src/sedp_decode.sv
src/sedp_out.sv
src/stx_etx_dle_frame_parser.sv
verif/tb_stx_etx_dle_frame_parser.sv
